// ----- rtl/sia_pkg.sv -----
// shared types and constants for the signed integer alu
package sia_pkg;

  localparam int unsigned DataWidthDefault = 64;
  localparam int unsigned OpWidth = 4;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [OpWidth-1:0] {
    OP_NEG = 4'd0,
    OP_NOT = 4'd1,
    OP_ADD = 4'd2,
    OP_SUB = 4'd3,
    OP_MUL = 4'd4,
    OP_DIV = 4'd5,
    OP_REM = 4'd6,
    OP_LT  = 4'd7,
    OP_GT  = 4'd8,
    OP_EQ  = 4'd9,
    OP_NE  = 4'd10,
    OP_LE  = 4'd11,
    OP_GE  = 4'd12,
    OP_AND = 4'd13,
    OP_OR  = 4'd14,
    OP_XOR = 4'd15
  } opcode_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_DIV_OVF  = 2'd2
  } status_e;

endpackage

// ----- rtl/sia_if.sv -----
// valid/ready channel interfaces for the alu operands and results
interface sia_req_if;
  import sia_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [OpWidth-1:0]           opcode;
  logic signed [ValueWidth-1:0] operand_a;
  logic signed [ValueWidth-1:0] operand_b;
  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface sia_rsp_if;
  import sia_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [ValueWidth-1:0] result_value;
  logic                         result_is_bool;
  logic [StatusWidth-1:0]       status;
  modport source (output valid, result_value, result_is_bool, status, input ready);
  modport sink (input valid, result_value, result_is_bool, status, output ready);
endinterface

// ----- rtl/signed_integer_alu_top.sv -----
// pipelined signed integer alu with radix-2 divider stages
// throughput: one item per cycle while the result output is not stalled;
// each divider stage retires one quotient bit
// multiply is split into three 32x32 partial products summed over two stages
// a stall freezes the whole pipeline, so nothing is lost or repeated
// reset clears all valid bits; payload registers are not reset
module signed_integer_alu_top #(
  parameter int unsigned DATA_WIDTH = sia_pkg::DataWidthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  sia_req_if.sink   req,
  sia_rsp_if.source rsp
);
  import sia_pkg::*;

  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned H = 32;
  localparam int unsigned NS = W + 4;

  typedef struct packed {
    logic [OpWidth-1:0]     op;
    logic [W-1:0]           res;
    logic                   is_bool;
    logic [StatusWidth-1:0] status;
    logic                   neg_q;
    logic                   neg_r;
    logic [W-1:0]           rem;
    logic [W-1:0]           quo;
    logic [W-1:0]           divr;
  } stage_t;

  logic          adv;
  logic [NS-1:0] v_q;
  stage_t        s_q [NS];
  stage_t        s_d [NS];

  logic [63:0]      mp_q [3];
  logic [ValueWidth-1:0] mp_d [3];
  logic [ValueWidth-1:0] ms_q;
  logic [ValueWidth-1:0] ms_d;

  assign adv = !v_q[NS-1] || rsp.ready;
  assign req.ready = adv;

  // stage 0: decode, simple ops, operand magnitudes, special cases
  logic [W-1:0] a, b, ma, mb, minv;
  logic         an, bn, slt, sgt, eqv;
  always_comb begin
    a = req.operand_a[W-1:0];
    b = req.operand_b[W-1:0];
    an = a[W-1];
    bn = b[W-1];
    ma = an ? (~a + 1'b1) : a;
    mb = bn ? (~b + 1'b1) : b;
    minv = {1'b1, {(W-1){1'b0}}};
    slt = $signed(a) < $signed(b);
    sgt = $signed(b) < $signed(a);
    eqv = a == b;
    s_d[0] = '0;
    s_d[0].op = req.opcode;
    s_d[0].neg_q = an ^ bn;
    s_d[0].neg_r = an;
    s_d[0].quo = ma;
    s_d[0].divr = mb;
    unique case (opcode_e'(req.opcode))
      OP_NEG: s_d[0].res = ~a + 1'b1;
      OP_NOT: s_d[0].res = ~a;
      OP_ADD: s_d[0].res = a + b;
      OP_SUB: s_d[0].res = a - b;
      OP_MUL: s_d[0].res = '0;
      OP_DIV, OP_REM: begin
        if (b == '0) begin
          s_d[0].status = ST_DIV_ZERO;
        end else if (a == minv && b == '1) begin
          s_d[0].status = ST_DIV_OVF;
          s_d[0].res = (opcode_e'(req.opcode) == OP_DIV) ? minv : '0;
        end
      end
      OP_LT: begin s_d[0].res = W'(slt); s_d[0].is_bool = 1'b1; end
      OP_GT: begin s_d[0].res = W'(sgt); s_d[0].is_bool = 1'b1; end
      OP_EQ: begin s_d[0].res = W'(eqv); s_d[0].is_bool = 1'b1; end
      OP_NE: begin s_d[0].res = W'(!eqv); s_d[0].is_bool = 1'b1; end
      OP_LE: begin s_d[0].res = W'(!sgt); s_d[0].is_bool = 1'b1; end
      OP_GE: begin s_d[0].res = W'(!slt); s_d[0].is_bool = 1'b1; end
      OP_AND: s_d[0].res = a & b;
      OP_OR:  s_d[0].res = a | b;
      OP_XOR: s_d[0].res = a ^ b;
      default: s_d[0].res = '0;
    endcase
  end

  // multiply partial products, low word aligned
  logic [H-1:0] al, ah, bl, bh;
  always_comb begin
    al = req.operand_a[H-1:0];
    ah = req.operand_a[63:H];
    bl = req.operand_b[H-1:0];
    bh = req.operand_b[63:H];
    mp_d[0] = ValueWidth'(al) * ValueWidth'(bl);
    mp_d[1] = ValueWidth'(al) * ValueWidth'(bh);
    mp_d[2] = ValueWidth'(ah) * ValueWidth'(bl);
    ms_d = mp_q[0] + {mp_q[1][H-1:0], {H{1'b0}}} + {mp_q[2][H-1:0], {H{1'b0}}};
  end

  // stages 1..W: one restoring divide step each
  for (genvar i = 1; i <= W; i++) begin : g_div
    logic [W:0] trial;
    logic [W-1:0] sh;
    always_comb begin
      s_d[i] = s_q[i-1];
      sh = {s_q[i-1].rem[W-2:0], s_q[i-1].quo[W-1]};
      trial = {1'b0, sh} - {1'b0, s_q[i-1].divr};
      s_d[i].quo = {s_q[i-1].quo[W-2:0], !trial[W]};
      s_d[i].rem = trial[W] ? sh : trial[W-1:0];
    end
  end

  // stage W+1: sign fix of divide results
  always_comb begin
    s_d[W+1] = s_q[W];
    if ((opcode_e'(s_q[W].op) == OP_DIV || opcode_e'(s_q[W].op) == OP_REM)
        && status_e'(s_q[W].status) == ST_OK) begin
      if (opcode_e'(s_q[W].op) == OP_DIV) begin
        s_d[W+1].res = s_q[W].neg_q ? (~s_q[W].quo + 1'b1) : s_q[W].quo;
      end else begin
        s_d[W+1].res = s_q[W].neg_r ? (~s_q[W].rem + 1'b1) : s_q[W].rem;
      end
    end
  end

  // multiply path: product shifted down the pipe alongside
  logic [ValueWidth-1:0] mline_q [2:W+2];
  always_comb begin
    s_d[W+2] = s_q[W+1];
    s_d[W+3] = s_q[W+2];
    if (opcode_e'(s_q[W+2].op) == OP_MUL) begin
      s_d[W+3].res = mline_q[W+2][W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], req.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        s_q[k] <= s_d[k];
      end
      for (int k = 0; k < 3; k++) begin
        mp_q[k] <= mp_d[k];
      end
      ms_q <= ms_d;
      mline_q[2] <= ms_q;
      for (int k = 3; k < W + 3; k++) begin
        mline_q[k] <= mline_q[k-1];
      end
    end
  end

  assign rsp.valid = v_q[NS-1];
  assign rsp.result_value = ValueWidth'($signed(s_q[NS-1].res));
  assign rsp.result_is_bool = s_q[NS-1].is_bool;
  assign rsp.status = s_q[NS-1].status;

endmodule

// ----- bench/tb_signed_integer_alu_top.sv -----
// self-checking bench for the signed integer alu: directed table, then random items
module tb_signed_integer_alu_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sia_pkg::*;

  localparam int unsigned Dw = DataWidthDefault;
  localparam int unsigned Latency = Dw + 3;
  localparam int unsigned RandomItems = 1830;
  localparam logic [63:0] MinVal = 64'h8000000000000000;
  localparam logic [63:0] MaxVal = 64'h7fffffffffffffff;
  localparam logic [63:0] AllOnes = 64'hffffffffffffffff;

  typedef struct packed {
    logic [63:0] value;
    logic        is_bool;
    logic [1:0]  status;
  } alu_result_t;

  typedef struct {
    opcode_e     op;
    logic [63:0] a;
    logic [63:0] b;
    logic        known;
    alu_result_t res;
  } vector_t;

  logic clk_i;
  logic rst_ni;
  sia_req_if req ();
  sia_rsp_if rsp ();

  signed_integer_alu_top #(.DATA_WIDTH(Dw)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req),
    .rsp   (rsp)
  );

  alu_result_t pending_results[$];
  vector_t     vectors[$];
  int          mismatches;
  bit          quiet;
  bit          hold_rsp;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("tb_signed_integer_alu_top failed");
    $finish;
  end

  function automatic alu_result_t alu_predict(opcode_e op, logic [63:0] a, logic [63:0] b);
    alu_result_t res;
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] q;
    sa = a;
    sb = b;
    res = '0;
    case (op)
      OP_NEG: res.value = 64'd0 - a;
      OP_NOT: res.value = ~a;
      OP_ADD: res.value = a + b;
      OP_SUB: res.value = a - b;
      OP_MUL: res.value = a * b;
      OP_DIV, OP_REM: begin
        if (b == 64'd0) begin
          res.status = ST_DIV_ZERO;
        end else if (a == MinVal && b == AllOnes) begin
          res.status = ST_DIV_OVF;
          res.value = (op == OP_DIV) ? MinVal : 64'd0;
        end else begin
          ua = a[63] ? 64'd0 - a : a;
          ub = b[63] ? 64'd0 - b : b;
          if (op == OP_DIV) begin
            q = ua / ub;
            res.value = (a[63] != b[63]) ? 64'd0 - q : q;
          end else begin
            q = ua % ub;
            res.value = a[63] ? 64'd0 - q : q;
          end
        end
      end
      OP_LT: res.value = 64'(sa < sb);
      OP_GT: res.value = 64'(sa > sb);
      OP_EQ: res.value = 64'(a == b);
      OP_NE: res.value = 64'(a != b);
      OP_LE: res.value = 64'(sa <= sb);
      OP_GE: res.value = 64'(sa >= sb);
      OP_AND: res.value = a & b;
      OP_OR: res.value = a | b;
      default: res.value = a ^ b;
    endcase
    if (op inside {OP_LT, OP_GT, OP_EQ, OP_NE, OP_LE, OP_GE}) res.is_bool = 1'b1;
    return res;
  endfunction

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MinVal;
      1: return MaxVal;
      2: return AllOnes;
      3: return 64'd0;
      4: return 64'($signed($urandom_range(0, 40)) - 20);
      5: return 64'($urandom);
      6: return {{32{1'b1}}, 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic add_row(opcode_e op, logic [63:0] a, logic [63:0] b, logic known,
                         logic [63:0] value, logic is_bool, status_e st);
    vector_t v;
    v.op = op;
    v.a = a;
    v.b = b;
    v.known = known;
    v.res = '{value: value, is_bool: is_bool, status: st};
    vectors.push_back(v);
  endtask

  task automatic build_table();
    add_row(OP_NEG, MinVal, 64'd0, 1'b1, MinVal, 1'b0, ST_OK);
    add_row(OP_NEG, MaxVal, AllOnes, 1'b1, MinVal + 64'd1, 1'b0, ST_OK);
    add_row(OP_NOT, 64'd0, MaxVal, 1'b1, AllOnes, 1'b0, ST_OK);
    add_row(OP_ADD, MaxVal, 64'd1, 1'b1, MinVal, 1'b0, ST_OK);
    add_row(OP_SUB, MinVal, 64'd1, 1'b1, MaxVal, 1'b0, ST_OK);
    add_row(OP_MUL, MinVal, AllOnes, 1'b1, MinVal, 1'b0, ST_OK);
    add_row(OP_MUL, 64'hdeadbeef12345678, 64'h0fedcba987654321, 1'b0, 64'd0, 1'b0, ST_OK);
    add_row(OP_DIV, MaxVal, 64'd0, 1'b1, 64'd0, 1'b0, ST_DIV_ZERO);
    add_row(OP_REM, MinVal, 64'd0, 1'b1, 64'd0, 1'b0, ST_DIV_ZERO);
    add_row(OP_DIV, MinVal, AllOnes, 1'b1, MinVal, 1'b0, ST_DIV_OVF);
    add_row(OP_REM, MinVal, AllOnes, 1'b1, 64'd0, 1'b0, ST_DIV_OVF);
    add_row(OP_DIV, -64'sd7, 64'd2, 1'b1, -64'sd3, 1'b0, ST_OK);
    add_row(OP_REM, -64'sd7, 64'd2, 1'b1, AllOnes, 1'b0, ST_OK);
    add_row(OP_REM, 64'd7, -64'sd2, 1'b1, 64'd1, 1'b0, ST_OK);
    add_row(OP_DIV, MinVal, 64'd1, 1'b1, MinVal, 1'b0, ST_OK);
    add_row(OP_DIV, MaxVal, MinVal, 1'b1, 64'd0, 1'b0, ST_OK);
    add_row(OP_LT, MinVal, MaxVal, 1'b1, 64'd1, 1'b1, ST_OK);
    add_row(OP_GT, MinVal, MaxVal, 1'b1, 64'd0, 1'b1, ST_OK);
    add_row(OP_EQ, AllOnes, AllOnes, 1'b1, 64'd1, 1'b1, ST_OK);
    add_row(OP_NE, AllOnes, AllOnes, 1'b1, 64'd0, 1'b1, ST_OK);
    add_row(OP_LE, MaxVal, MaxVal, 1'b1, 64'd1, 1'b1, ST_OK);
    add_row(OP_GE, AllOnes, 64'd0, 1'b1, 64'd0, 1'b1, ST_OK);
    add_row(OP_AND, AllOnes, MinVal, 1'b1, MinVal, 1'b0, ST_OK);
    add_row(OP_OR, MinVal, MaxVal, 1'b1, AllOnes, 1'b0, ST_OK);
    add_row(OP_XOR, AllOnes, MaxVal, 1'b1, MinVal, 1'b0, ST_OK);
  endtask

  task automatic send_item(opcode_e op, logic [63:0] a, logic [63:0] b);
    req.valid <= 1'b1;
    req.opcode <= op;
    req.operand_a <= a;
    req.operand_b <= b;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      req.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && req.valid && req.ready) begin
      pending_results.push_back(alu_predict(opcode_e'(req.opcode), req.operand_a,
                                            req.operand_b));
    end
  end

  always @(posedge clk_i) begin
    alu_result_t exp_res;
    alu_result_t got;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got = '{value: rsp.result_value, is_bool: rsp.result_is_bool, status: rsp.status};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_res = pending_results.pop_front();
        if (got !== exp_res) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected value %h bool %b status %0d, got %h %b %0d",
                     exp_res.value, exp_res.is_bool, exp_res.status,
                     got.value, got.is_bool, got.status);
          end
        end
      end
    end
  end

  // sink side idling, with one long hold-off
  initial begin
    int n;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        n = 0;
        while (n < 3 * Latency) begin
          @(posedge clk_i);
          n++;
        end
        hold_rsp = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        rsp.ready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    int waited;
    vector_t v;
    req.valid = 1'b0;
    req.opcode = '0;
    req.operand_a = '0;
    req.operand_b = '0;
    mismatches = 0;
    quiet = 0;
    hold_rsp = 0;
    rst_ni = 1'b0;
    build_table();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (vectors[i]) begin
      v = vectors[i];
      if (v.known && alu_predict(v.op, v.a, v.b) !== v.res) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
      end
      send_item(v.op, v.a, v.b);
      sender_gap();
    end
    for (int i = 0; i < RandomItems; i++) begin
      if (i == 300) hold_rsp = 1'b1;
      if (i == RandomItems - 300) quiet = 1'b1;
      send_item(opcode_e'($urandom_range(0, 15)), pick_operand(), pick_operand());
      sender_gap();
    end
    req.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (2 * Latency) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_signed_integer_alu_top passed");
    end else begin
      $display("tb_signed_integer_alu_top failed");
    end
    $finish;
  end

endmodule
